/* hdl/response_frame_receiver_assert.svh */
// assertion macros for the response frame receiver
// no dependencies; included by the top level
`ifndef RESPONSE_FRAME_RECEIVER_ASSERT_SVH
`define RESPONSE_FRAME_RECEIVER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define RFR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("response_frame_receiver assertion failed");

// next-cycle implication
`define RFR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("response_frame_receiver assertion failed");

`else

`define RFR_ASSERT_NOW(label, clk, rst, ante, cons)
`define RFR_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* hdl/rfr_pkg.sv */
// shared types and constants for the response frame receiver
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rfr_pkg;

   // operation codes
   localparam logic [1:0] OP_ARM  = 2'd0;
   localparam logic [1:0] OP_BYTE = 2'd1;
   localparam logic [1:0] OP_TICK = 2'd2;

   // status codes on the result channel
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_RECV   = 3'd1;
   localparam logic [2:0] ST_DONE   = 3'd2;
   localparam logic [2:0] ST_BADID  = 3'd3;
   localparam logic [2:0] ST_BADSUM = 3'd4;
   localparam logic [2:0] ST_ERR    = 3'd5;

   localparam logic [7:0]  MIN_LENGTH    = 8'd2;
   localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

   typedef struct packed {
      logic [1:0] operation;
      logic [7:0] data_byte;
      logic [7:0] expected_id;
   } req_item_type;

   typedef struct packed {
      logic [2:0] status;
      logic       done_res;
      logic       byte_valid;
      logic [7:0] byte_index;
      logic [7:0] byte_out;
   } rsp_item_type;

endpackage

`default_nettype wire

/* hdl/rfr_in_stage.sv */
// input register stage of the response frame receiver
// depends on rfr_pkg
`timescale 1ns / 1ps
`default_nettype none

module rfr_in_stage (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   load,
   input  wire                   advance,
   input  rfr_pkg::req_item_type item,
   output logic                  stage_valid,
   output rfr_pkg::req_item_type stage_item
);
   import rfr_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;

   assign valid_in = load ? 1'b1 : (advance ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= item;
      end
   end

   assign stage_valid = valid_ff;
   assign stage_item  = item_ff;

endmodule

`default_nettype wire

/* hdl/rfr_frame_core.sv */
// frame state and per-item update of the response frame receiver
// depends on rfr_pkg
`timescale 1ns / 1ps
`default_nettype none

module rfr_frame_core #(
   parameter int TICK_COUNT_WIDTH = 17
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   advance,
   input  rfr_pkg::req_item_type item,
   input  wire [15:0]            timeout_ticks,
   output rfr_pkg::rsp_item_type result
);
   import rfr_pkg::*;

   localparam int CMP_W = (TICK_COUNT_WIDTH > 16) ? TICK_COUNT_WIDTH : 16;

   typedef enum logic [5:0] {
      PH_IDLE   = 6'b000001,
      PH_RECV   = 6'b000010,
      PH_DONE   = 6'b000100,
      PH_BADID  = 6'b001000,
      PH_BADSUM = 6'b010000,
      PH_ERR    = 6'b100000
   } phase_type;

   phase_type                     phase_ff, phase_in;
   logic [7:0]                    awaited_ff, awaited_in;
   logic [7:0]                    length_ff, length_in;
   logic [8:0]                    count_ff, count_in;
   logic [7:0]                    xor_ff, xor_in;
   logic [7:0]                    rid_ff, rid_in;
   logic [TICK_COUNT_WIDTH-1:0]   ticks_ff, ticks_in;
   logic [7:0]                    length_eff;
   logic [7:0]                    rid_eff;
   logic                          done;
   logic                          byte_ok;

   always_comb begin
      phase_in   = phase_ff;
      awaited_in = awaited_ff;
      length_in  = length_ff;
      count_in   = count_ff;
      xor_in     = xor_ff;
      rid_in     = rid_ff;
      ticks_in   = ticks_ff;
      done       = 1'b0;
      byte_ok    = 1'b0;
      length_eff = (count_ff == 9'd0) ? item.data_byte : length_ff;
      rid_eff    = (count_ff == 9'd1) ? item.data_byte : rid_ff;
      case (item.operation)
         OP_ARM: begin
            if (item.expected_id != 8'd0) begin
               awaited_in = item.expected_id;
               length_in  = 8'd0;
               count_in   = 9'd0;
               xor_in     = 8'd0;
               rid_in     = 8'd0;
               ticks_in   = '0;
               phase_in   = PH_RECV;
            end
         end
         OP_BYTE: begin
            if (phase_ff == PH_RECV) begin
               if (count_ff == 9'd0 && item.data_byte < MIN_LENGTH) begin
                  // length byte too short
                  phase_in = PH_ERR;
                  done     = 1'b1;
               end else begin
                  byte_ok   = 1'b1;
                  length_in = length_eff;
                  rid_in    = rid_eff;
                  if (count_ff == {1'b0, length_eff}) begin
                     // checksum byte
                     if (xor_ff == item.data_byte) begin
                        phase_in = (rid_eff == awaited_ff) ? PH_DONE : PH_BADID;
                     end else begin
                        phase_in = PH_BADSUM;
                     end
                     done = 1'b1;
                  end else begin
                     xor_in = xor_ff ^ item.data_byte;
                  end
                  count_in = count_ff + 9'd1;
               end
            end
         end
         OP_TICK: begin
            if (ticks_ff != '1) begin
               ticks_in = ticks_ff + 1'b1;
            end
            if (phase_ff == PH_RECV &&
                CMP_W'(ticks_in) > CMP_W'(timeout_ticks)) begin
               phase_in = PH_ERR;
               done     = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         awaited_ff <= 8'd0;
         length_ff  <= 8'd0;
         count_ff   <= 9'd0;
         xor_ff     <= 8'd0;
         rid_ff     <= 8'd0;
         ticks_ff   <= '0;
      end else if (advance) begin
         phase_ff   <= phase_in;
         awaited_ff <= awaited_in;
         length_ff  <= length_in;
         count_ff   <= count_in;
         xor_ff     <= xor_in;
         rid_ff     <= rid_in;
         ticks_ff   <= ticks_in;
      end
   end

   always_comb begin
      case (phase_in)
         PH_IDLE:   result.status = ST_IDLE;
         PH_RECV:   result.status = ST_RECV;
         PH_DONE:   result.status = ST_DONE;
         PH_BADID:  result.status = ST_BADID;
         PH_BADSUM: result.status = ST_BADSUM;
         PH_ERR:    result.status = ST_ERR;
         default:   result.status = ST_IDLE;
      endcase
      result.done_res   = done;
      result.byte_valid = byte_ok;
      result.byte_index = byte_ok ? count_ff[7:0] : 8'd0;
      result.byte_out   = byte_ok ? item.data_byte : 8'd0;
   end

endmodule

`default_nettype wire

/* hdl/rfr_out_stage.sv */
// result register stage of the response frame receiver
// depends on rfr_pkg
`timescale 1ns / 1ps
`default_nettype none

module rfr_out_stage (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   load,
   input  wire                   stall,
   input  rfr_pkg::rsp_item_type result,
   output logic                  out_valid,
   output rfr_pkg::rsp_item_type out_item
);
   import rfr_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   rsp_item_type item_ff;

   assign valid_in = load ? 1'b1 : (stall ? valid_ff : 1'b0);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= result;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

`default_nettype wire

/* hdl/response_frame_receiver.sv */
// response frame receiver: length-prefixed frames with xor checksum
// usage: the req_ channel carries arm, byte and tick transfers; every
//   transfer gives exactly one rsp_ transfer with status and, for an accepted byte, the echoed byte
// path: a req_ transfer taken on req_ passes through one input register and
//   one result register before it is offered on rsp_
// throughput: one transfer per cycle while rsp_stall is low; the frame state update is a single
//   compare, xor and count step between the two registers
// stall: rsp_stall holds the result register; the input register still takes
//   one more transfer, and req_stall rises only when both registers are full
// csr_: one write-only register, timeout_ticks, always ready
// reset: synchronous; phase idle, all counts zero, timeout_ticks 1000
// depends on rfr_pkg, rfr_in_stage, rfr_frame_core, rfr_out_stage
// and response_frame_receiver_assert.svh
`timescale 1ns / 1ps
`default_nettype none

`include "response_frame_receiver_assert.svh"

module response_frame_receiver #(
   parameter int TICK_COUNT_WIDTH = 17
) (
   input  wire        clock,
   input  wire        reset,
   // request channel
   input  wire        req_valid,
   output logic       req_stall,
   input  wire [1:0]  req_operation,
   input  wire [7:0]  req_data_byte,
   input  wire [7:0]  req_expected_id,
   // response channel
   output logic       rsp_valid,
   input  wire        rsp_stall,
   output logic [2:0] rsp_status,
   output logic       rsp_done_res,
   output logic       rsp_byte_valid,
   output logic [7:0] rsp_byte_index,
   output logic [7:0] rsp_byte_out,
   // register write channel
   input  wire        csr_valid,
   output logic       csr_ready,
   input  wire [15:0] csr_wdata
);
   import rfr_pkg::*;

   req_item_type req_item;
   req_item_type s1_item;
   rsp_item_type core_result;
   rsp_item_type rsp_item;
   logic         s1_valid;
   logic         out_free;
   logic         s1_fire;
   logic         req_take;
   logic [15:0]  timeout_ff;

   assign req_item.operation   = req_operation;
   assign req_item.data_byte   = req_data_byte;
   assign req_item.expected_id = req_expected_id;

   // result register is free when empty or being drained this cycle
   assign out_free  = !rsp_valid || !rsp_stall;
   assign s1_fire   = s1_valid && out_free;
   assign req_stall = s1_valid && !out_free;
   assign req_take  = req_valid && !req_stall;

   // timeout register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
      end else if (csr_valid && csr_ready) begin
         timeout_ff <= csr_wdata;
      end
   end

   rfr_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .load        (req_take),
      .advance     (s1_fire),
      .item        (req_item),
      .stage_valid (s1_valid),
      .stage_item  (s1_item)
   );

   // frame state moves only when the held transfer goes to the result register
   rfr_frame_core #(
      .TICK_COUNT_WIDTH (TICK_COUNT_WIDTH)
   ) u_frame_core (
      .clock         (clock),
      .reset         (reset),
      .advance       (s1_fire),
      .item          (s1_item),
      .timeout_ticks (timeout_ff),
      .result        (core_result)
   );

   rfr_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (s1_fire),
      .stall     (rsp_stall),
      .result    (core_result),
      .out_valid (rsp_valid),
      .out_item  (rsp_item)
   );

   assign rsp_status     = rsp_item.status;
   assign rsp_done_res   = rsp_item.done_res;
   assign rsp_byte_valid = rsp_item.byte_valid;
   assign rsp_byte_index = rsp_item.byte_index;
   assign rsp_byte_out   = rsp_item.byte_out;

   // a transfer leaving the input register always lands in the result register
   `RFR_ASSERT_NEXT(a_fire_lands, clock, reset, s1_fire, rsp_valid)
   // a taken transfer is held in the input register next cycle
   `RFR_ASSERT_NEXT(a_take_held, clock, reset, req_take, s1_valid)
   // a frame end always reports a final status
   `RFR_ASSERT_NOW(a_done_final, clock, reset, rsp_valid && rsp_done_res,
      rsp_status == ST_DONE || rsp_status == ST_BADID ||
      rsp_status == ST_BADSUM || rsp_status == ST_ERR)
   // a byte taken without ending the frame leaves reception running
   `RFR_ASSERT_NOW(a_byte_recv, clock, reset,
      rsp_valid && rsp_byte_valid && !rsp_done_res, rsp_status == ST_RECV)

endmodule

`default_nettype wire
